FILE: rtl/mcd_pkg.sv
// Shared types, constants and helper functions of the metafile command decoder.
`timescale 1ns / 1ps
`default_nettype none
package mcd_pkg;

  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = 8;
  localparam int HDR_N     = 10;

  // Reciprocal for truncating division of a 23-bit magnitude by 1000
  localparam logic [23:0] DIV_RECIP = 24'd8589935;
  localparam int          DIV_SHIFT = 33;
  // Reciprocal for division of a 16-bit magnitude by 11
  localparam logic [16:0] MOD_RECIP = 17'd95326;
  localparam int          MOD_SHIFT = 20;
  localparam logic [15:0] MSIZE_RST = 16'd6;

  // Result kinds
  typedef enum logic [3:0] {
    K_MOVE, K_DRAW, K_BEGIN, K_VERTEX, K_END, K_MARKER,
    K_TSTART, K_CHAR, K_TEND, K_COLOR, K_WIDTH, K_ERROR
  } kind_t;

  typedef enum logic [2:0] {PH_OP, PH_HDR, PH_XS, PH_YS, PH_TEXT, PH_PAL} phase_t;

  typedef enum logic [2:0] {BK_IDLE, BK_RUN, BK_RDWAIT, BK_MUL, BK_DIV} bk_state_t;

  // Opcodes
  localparam logic [7:0] OP_MOVE   = 8'd1;
  localparam logic [7:0] OP_DRAW   = 8'd2;
  localparam logic [7:0] OP_PLINE  = 8'd3;
  localparam logic [7:0] OP_PGON   = 8'd4;
  localparam logic [7:0] OP_PMARK  = 8'd5;
  localparam logic [7:0] OP_TEXT   = 8'd6;
  localparam logic [7:0] OP_CTEXT  = 8'd7;
  localparam logic [7:0] OP_LWIDTH = 8'd8;
  localparam logic [7:0] OP_MARKER = 8'd9;
  localparam logic [7:0] OP_MSIZE  = 8'd10;
  localparam logic [7:0] OP_TSIZE  = 8'd11;
  localparam logic [7:0] OP_SETCOL = 8'd12;
  localparam logic [7:0] OP_SETENT = 8'd13;
  localparam logic [7:0] OP_SETPAL = 8'd14;
  localparam logic [7:0] OP_NLINE  = 8'd15;
  localparam logic [7:0] OP_NPLINE = 8'd16;
  localparam logic [7:0] OP_NPGON  = 8'd17;
  localparam logic [7:0] OP_NPMARK = 8'd18;
  localparam logic [7:0] OP_NTEXT1 = 8'd19;
  localparam logic [7:0] OP_NTEXT2 = 8'd20;
  localparam logic [7:0] OP_SHADE  = 8'd21;
  localparam logic [7:0] OP_NOP    = 8'd0;

  // Result flags of a job, in emission order
  localparam int F_WIDTH = 0;
  localparam int F_COL1  = 1;
  localparam int F_BEGIN = 2;
  localparam int F_POS1  = 3;
  localparam int F_POS2  = 4;
  localparam int F_END   = 5;
  localparam int F_COL2  = 6;
  localparam int F_CHR   = 7;
  localparam int F_TEND  = 8;
  localparam int F_ERR   = 9;
  localparam int NFLAGS  = 10;

  // One request from the parser to the executer
  typedef struct packed {
    logic [NFLAGS-1:0] flags;
    logic              palwr;
    logic              shade;
    kind_t             pos1_kind;
    logic [15:0]       x1;
    logic [15:0]       y1;
    logic [15:0]       x2;
    logic [15:0]       y2;
    logic [15:0]       lwidth;
    logic [15:0]       inten;
    logic [7:0]        cidx;
    logic [23:0]       pal_data;
    logic [4:0]        mkind;
    logic [14:0]       mhalf;
    logic [7:0]        chr;
  } job_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [14:0] red;
    logic [14:0] green;
    logic [14:0] blue;
    logic [15:0] line_width;
    logic [4:0]  marker_kind;
    logic [14:0] marker_half;
    logic [7:0]  text_char;
    logic        last;
  } res_t;

  // Header bytes that follow each opcode
  function automatic logic [3:0] hdr_len(input logic [7:0] op);
    logic [3:0] n;
    case (op)
      OP_MOVE, OP_DRAW, OP_SETENT, OP_NPLINE, OP_SHADE: n = 4'd4;
      OP_CTEXT:                                        n = 4'd6;
      OP_SETCOL:                                       n = 4'd1;
      OP_NLINE:                                        n = 4'd10;
      OP_NPGON:                                        n = 4'd3;
      OP_NPMARK:                                       n = 4'd5;
      OP_NTEXT1, OP_NTEXT2:                            n = 4'd8;
      default:                                         n = 4'd2;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] join16(input logic bo, input logic [7:0] first,
                                         input logic [7:0] second);
    return bo ? {first, second} : {second, first};
  endfunction

  // Signed remainder by 11, truncated toward zero
  function automatic logic [4:0] mod11(input logic [15:0] v);
    logic [15:0] a;
    logic [32:0] p;
    logic [15:0] q;
    logic [15:0] r;
    logic [4:0]  rem;
    a   = v[15] ? 16'(-v) : v;
    p   = 33'(a) * 33'(MOD_RECIP);
    q   = 16'(p >> MOD_SHIFT);
    r   = a - 16'(q * 16'd11);
    rem = {1'b0, r[3:0]};
    return v[15] ? 5'(-rem) : rem;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mcd_ifs.sv
// Channel interfaces of the metafile command decoder.
`timescale 1ns / 1ps
`default_nettype none
interface mcd_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, data_byte, restart, input ready);
  modport sink (input valid, data_byte, restart, output ready);
endinterface

interface mcd_cfg_if;
  logic valid;
  logic ready;
  logic byte_order;
  modport source (output valid, byte_order, input ready);
  modport sink (input valid, byte_order, output ready);
endinterface

interface mcd_prim_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [14:0] red;
  logic [14:0] green;
  logic [14:0] blue;
  logic [15:0] line_width;
  logic [4:0]  marker_kind;
  logic [14:0] marker_half;
  logic [7:0]  text_char;
  logic        last;
  modport source (output valid, kind, pos_x, pos_y, red, green, blue, line_width,
                  marker_kind, marker_half, text_char, last, input ready);
  modport sink (input valid, kind, pos_x, pos_y, red, green, blue, line_width,
                marker_kind, marker_half, text_char, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/mcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/mcd_queue.sv
// Short request queue between the parser and the executer.
`timescale 1ns / 1ps
`default_nettype none
module mcd_queue import mcd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic full,
  output logic empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t            mem [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [AW:0]     count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
endmodule
`default_nettype wire

FILE: rtl/mcd_front.sv
// Command parser: splits the byte stream into commands and issues requests.
`timescale 1ns / 1ps
`default_nettype none
module mcd_front import mcd_pkg::*; #(
  parameter int MAX_POINTS = 50,
  parameter int MAX_TEXT   = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       restart,
  input  logic       byte_order,
  output job_t       job,
  output logic       job_valid
);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int TW  = $clog2(MAX_TEXT);
  localparam int CW0 = (PW > 8) ? PW : 8;
  localparam int CW  = (TW > CW0) ? TW : CW0;
  localparam int XD  = MAX_POINTS - 1;
  localparam int XAW = (XD > 1) ? $clog2(XD) : 1;

  phase_t       phase, phase_next, ph;
  logic         lock, lock_next, lk;
  logic [7:0]   opcode, opcode_next;
  logic [3:0]   hcnt, hcnt_next, hcnt_inc;
  logic [7:0]   hdr [HDR_N];
  logic [7:0]   hdr_next [HDR_N];
  logic [7:0]   hdr_cur [HDR_N];
  logic [15:0]  hw [HDR_N-1];
  logic         half, half_next;
  logic [1:0]   pcnt, pcnt_next;
  logic [CW-1:0] tcnt, tcnt_next, idx, idx_next, point_count, point_count_next;
  logic [CW:0]  tcnt_inc, idx_inc;
  logic [15:0]  partial, partial_next;
  logic [7:0]   shade_idx, shade_idx_next;
  logic [15:0]  mset, mset_next, msize, msize_next;
  logic [15:0]  text_x, text_x_next, text_y, text_y_next;
  logic         ended, ended_next;
  logic [15:0]  n_pts, n_txt, w;
  logic         pts_big, txt_big;
  logic [CW-1:0] pts_cnt, txt_cnt, sp_cnt;
  logic [16:0]  hs;
  logic         x_we, x_re;
  logic [15:0]  x_rd;

  mcd_ram #(.WIDTH(16), .DEPTH(XD)) u_xram (
    .clk   (clk),
    .we    (x_we),
    .waddr (idx[XAW-1:0]),
    .wdata (w),
    .re    (x_re),
    .raddr (idx[XAW-1:0]),
    .rdata (x_rd)
  );

  // header bytes including the one arriving now
  always_comb begin
    for (int k = 0; k < HDR_N; k++) begin
      hdr_cur[k] = (4'(k) == hcnt) ? data_byte : hdr[k];
    end
    for (int k = 0; k < HDR_N - 1; k++) begin
      hw[k] = join16(byte_order, hdr_cur[k], hdr_cur[k+1]);
    end
  end

  // count words and their limits
  always_comb begin
    case (opcode)
      OP_NPLINE: n_pts = hw[2];
      OP_NPGON:  n_pts = hw[1];
      OP_NPMARK: n_pts = hw[3];
      default:   n_pts = hw[0];
    endcase
    case (opcode)
      OP_CTEXT:             n_txt = hw[4];
      OP_NTEXT1, OP_NTEXT2: n_txt = hw[6];
      default:              n_txt = hw[0];
    endcase
    pts_big = !n_pts[15] && (n_pts >= 16'(MAX_POINTS));
    txt_big = !n_txt[15] && (n_txt >= 16'(MAX_TEXT - 1));
    pts_cnt = n_pts[15] ? '0 : n_pts[CW-1:0];
    txt_cnt = n_txt[15] ? '0 : n_txt[CW-1:0];
    sp_cnt  = (opcode == OP_SHADE) ? point_count : pts_cnt;
    hs      = {msize[15], msize} + 17'(msize[15]);
    hcnt_inc = hcnt + 4'd1;
    tcnt_inc = {1'b0, tcnt} + 1'b1;
    idx_inc  = {1'b0, idx} + 1'b1;
    w        = join16(byte_order, partial[7:0], data_byte);
  end

  // parse one byte
  always_comb begin
    phase_next       = phase;
    lock_next        = lock;
    opcode_next      = opcode;
    hcnt_next        = hcnt;
    hdr_next         = hdr;
    half_next        = half;
    pcnt_next        = pcnt;
    tcnt_next        = tcnt;
    idx_next         = idx;
    point_count_next = point_count;
    partial_next     = partial;
    shade_idx_next   = shade_idx;
    mset_next        = mset;
    msize_next       = msize;
    text_x_next      = text_x;
    text_y_next      = text_y;
    ended_next       = ended;
    ph               = phase;
    lk               = lock;
    x_we             = 1'b0;
    x_re             = 1'b0;
    job              = '0;
    job.pos1_kind    = K_MOVE;
    if (acc) begin
      if (restart) begin
        ph         = PH_OP;
        lk         = 1'b0;
        phase_next = PH_OP;
        lock_next  = 1'b0;
        mset_next  = '0;
        msize_next = MSIZE_RST;
      end
      if (!lk) begin
        case (ph)
          PH_OP: begin
            if (data_byte != OP_NOP && data_byte <= OP_SHADE) begin
              opcode_next = data_byte;
              hcnt_next   = '0;
              phase_next  = PH_HDR;
            end
          end
          PH_HDR: begin
            hdr_next  = hdr_cur;
            hcnt_next = hcnt_inc;
            if (opcode == OP_SHADE && hcnt == 4'd1 && pts_big) begin
              job.flags[F_ERR] = 1'b1;
              lock_next        = 1'b1;
              phase_next       = PH_OP;
            end else begin
              if (opcode == OP_SHADE && hcnt == 4'd1) begin
                point_count_next = pts_cnt;
              end
              if (hcnt_inc >= hdr_len(opcode)) begin
                // command header complete
                phase_next = PH_OP;
                case (opcode)
                  OP_MOVE, OP_DRAW: begin
                    text_x_next      = hw[0];
                    text_y_next      = hw[2];
                    job.flags[F_POS1] = 1'b1;
                    job.pos1_kind    = (opcode == OP_MOVE) ? K_MOVE : K_DRAW;
                    job.x1           = hw[0];
                    job.y1           = hw[2];
                  end
                  OP_PLINE, OP_PGON, OP_PMARK, OP_NPLINE, OP_NPGON, OP_NPMARK,
                  OP_SHADE: begin
                    if (opcode == OP_NPMARK) begin
                      mset_next  = {8'd0, hdr_cur[0]};
                      msize_next = {8'd0, hdr_cur[1]};
                    end
                    if (opcode != OP_SHADE && pts_big) begin
                      job.flags[F_ERR] = 1'b1;
                      lock_next        = 1'b1;
                    end else begin
                      if (opcode != OP_SHADE) begin
                        point_count_next = pts_cnt;
                      end
                      idx_next   = '0;
                      half_next  = 1'b0;
                      phase_next = (sp_cnt != '0) ? PH_XS : PH_OP;
                      case (opcode)
                        OP_NPLINE: begin
                          job.flags[F_WIDTH] = 1'b1;
                          job.lwidth         = {8'd0, hdr_cur[0]};
                          job.flags[F_COL1]  = 1'b1;
                          job.cidx           = hdr_cur[1];
                        end
                        OP_NPGON: begin
                          job.flags[F_COL1] = (pts_cnt >= CW'(3));
                          job.cidx          = hdr_cur[0];
                        end
                        OP_NPMARK: begin
                          job.flags[F_COL1] = 1'b1;
                          job.cidx          = hdr_cur[2];
                        end
                        OP_SHADE: begin
                          job.flags[F_COL1] = (point_count >= CW'(3));
                          job.shade         = 1'b1;
                          job.cidx          = shade_idx;
                          job.inten         = hw[2];
                        end
                        default: ;
                      endcase
                    end
                  end
                  OP_TEXT, OP_CTEXT, OP_NTEXT1, OP_NTEXT2: begin
                    if (opcode == OP_CTEXT) begin
                      text_x_next = hw[0];
                      text_y_next = hw[2];
                    end else if (opcode != OP_TEXT) begin
                      text_x_next = hw[2];
                      text_y_next = hw[4];
                    end
                    if (txt_big) begin
                      job.flags[F_ERR] = 1'b1;
                      lock_next        = 1'b1;
                    end else begin
                      point_count_next  = txt_cnt;
                      job.flags[F_COL1] = (opcode == OP_NTEXT1 || opcode == OP_NTEXT2);
                      job.cidx          = hdr_cur[1];
                      job.flags[F_POS1] = 1'b1;
                      job.pos1_kind     = K_TSTART;
                      job.x1            = text_x_next;
                      job.y1            = text_y_next;
                      ended_next        = 1'b0;
                      tcnt_next         = '0;
                      if (txt_cnt == '0) begin
                        job.flags[F_TEND] = 1'b1;
                      end else begin
                        phase_next = PH_TEXT;
                      end
                    end
                  end
                  OP_LWIDTH: begin
                    job.flags[F_WIDTH] = 1'b1;
                    job.lwidth         = hw[0];
                  end
                  OP_MARKER: mset_next  = hw[0];
                  OP_MSIZE:  msize_next = hw[0];
                  OP_SETCOL: begin
                    shade_idx_next    = hdr_cur[0];
                    job.flags[F_COL1] = 1'b1;
                    job.cidx          = hdr_cur[0];
                  end
                  OP_SETENT: begin
                    job.palwr    = 1'b1;
                    job.cidx     = hdr_cur[0];
                    job.pal_data = {hdr_cur[1], hdr_cur[2], hdr_cur[3]};
                  end
                  OP_SETPAL: begin
                    text_x_next = {8'd0, hdr_cur[0]};
                    text_y_next = {8'd0, hdr_cur[1]};
                    if (hdr_cur[0] <= hdr_cur[1]) begin
                      idx_next         = CW'(hdr_cur[0]);
                      point_count_next = CW'(hdr_cur[1]);
                      pcnt_next        = '0;
                      phase_next       = PH_PAL;
                    end
                  end
                  OP_NLINE: begin
                    job.flags[F_WIDTH] = 1'b1;
                    job.lwidth         = {8'd0, hdr_cur[0]};
                    job.flags[F_COL1]  = 1'b1;
                    job.cidx           = hdr_cur[1];
                    job.flags[F_POS1]  = 1'b1;
                    job.pos1_kind      = K_MOVE;
                    job.x1             = hw[2];
                    job.y1             = hw[4];
                    job.flags[F_POS2]  = 1'b1;
                    job.x2             = hw[6];
                    job.y2             = hw[8];
                  end
                  default: ;
                endcase
              end
            end
          end
          PH_XS, PH_YS: begin
            if (!half) begin
              partial_next = {8'd0, data_byte};
              half_next    = 1'b1;
              x_re         = (ph == PH_YS);
            end else begin
              half_next = 1'b0;
              if (idx >= CW'(MAX_POINTS - 1) || idx >= point_count) begin
                phase_next = PH_OP;
              end else if (ph == PH_XS) begin
                x_we = 1'b1;
                if (idx_inc >= {1'b0, point_count}) begin
                  idx_next   = '0;
                  phase_next = PH_YS;
                end else begin
                  idx_next = idx_inc[CW-1:0];
                end
              end else begin
                // one vertex
                idx_next = idx_inc[CW-1:0];
                if (idx_inc >= {1'b0, point_count}) begin
                  phase_next = PH_OP;
                end
                job.x1 = x_rd;
                job.y1 = w;
                case (opcode)
                  OP_PLINE, OP_NPLINE: begin
                    job.flags[F_POS1] = 1'b1;
                    job.pos1_kind     = (idx == '0) ? K_MOVE : K_DRAW;
                  end
                  OP_PMARK, OP_NPMARK: begin
                    job.flags[F_POS1] = 1'b1;
                    job.pos1_kind     = K_MARKER;
                    job.mkind         = mod11(mset);
                    job.mhalf         = hs[15:1];
                  end
                  OP_PGON, OP_NPGON, OP_SHADE: begin
                    if (point_count >= CW'(3)) begin
                      job.flags[F_BEGIN] = (idx == '0);
                      job.flags[F_POS1]  = 1'b1;
                      job.pos1_kind      = K_VERTEX;
                      job.flags[F_END]   = (idx_inc == {1'b0, point_count});
                      job.flags[F_COL2]  = (opcode == OP_SHADE) &&
                                           (idx_inc == {1'b0, point_count});
                      job.cidx           = shade_idx;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end
          PH_TEXT: begin
            if (!ended) begin
              if (data_byte == 8'd0) begin
                ended_next = 1'b1;
              end else begin
                job.flags[F_CHR] = 1'b1;
                job.chr          = data_byte;
              end
            end
            tcnt_next = tcnt_inc[CW-1:0];
            if (tcnt_inc >= {1'b0, point_count}) begin
              job.flags[F_TEND] = 1'b1;
              phase_next        = PH_OP;
            end
          end
          PH_PAL: begin
            if (pcnt != 2'd2) begin
              partial_next = {partial[7:0], data_byte};
              pcnt_next    = pcnt + 2'd1;
            end else begin
              pcnt_next    = '0;
              job.palwr    = 1'b1;
              job.cidx     = idx[7:0];
              job.pal_data = {partial, data_byte};
              if (idx >= point_count) begin
                phase_next = PH_OP;
              end else begin
                idx_next = idx_inc[CW-1:0];
              end
            end
          end
          default: phase_next = PH_OP;
        endcase
      end
    end
    job_valid = acc && ((job.flags != '0) || job.palwr);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OP;
      lock        <= 1'b0;
      opcode      <= OP_NOP;
      hcnt        <= '0;
      half        <= 1'b0;
      pcnt        <= '0;
      tcnt        <= '0;
      idx         <= '0;
      point_count <= '0;
      partial     <= '0;
      shade_idx   <= '0;
      mset        <= '0;
      msize       <= MSIZE_RST;
      text_x      <= '0;
      text_y      <= '0;
      ended       <= 1'b0;
    end else begin
      phase       <= phase_next;
      lock        <= lock_next;
      opcode      <= opcode_next;
      hcnt        <= hcnt_next;
      half        <= half_next;
      pcnt        <= pcnt_next;
      tcnt        <= tcnt_next;
      idx         <= idx_next;
      point_count <= point_count_next;
      partial     <= partial_next;
      shade_idx   <= shade_idx_next;
      mset        <= mset_next;
      msize       <= msize_next;
      text_x      <= text_x_next;
      text_y      <= text_y_next;
      ended       <= ended_next;
    end
  end

  // header bytes
  always_ff @(posedge clk) begin
    hdr <= hdr_next;
  end

  a_lock_quiet: assert property (@(posedge clk) disable iff (rst)
    (lock && acc && !restart) |-> !job_valid)
    else $error("request issued while locked");
endmodule
`default_nettype wire

FILE: rtl/mcd_back.sv
// Executer: expands requests into primitives, owns the palette.
`timescale 1ns / 1ps
`default_nettype none
module mcd_back import mcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_job,
  output logic q_pop,
  output res_t out,
  output logic out_valid,
  input  logic out_ready
);
  bk_state_t          state, state_next;
  job_t               job, job_next;
  logic [NFLAGS-1:0]  flags, flags_next, remaining;
  logic [3:0]         fsel;
  logic               found, slot_free, emit, load, last;
  res_t               res;
  logic [PAL_DEPTH-1:0] pal_valid;
  logic               rd_vld;
  logic               ram_we, ram_re;
  logic [PAL_AW-1:0]  ram_raddr;
  logic [23:0]        ram_rdata, col;
  logic signed [24:0] prod [3];
  logic               neg [3];
  logic [47:0]        quot [3];
  logic [23:0]        mag [3];
  logic               do_mul, do_div;

  mcd_ram #(.WIDTH(24), .DEPTH(PAL_DEPTH)) u_pal (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_job.cidx),
    .wdata (q_job.pal_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign col       = rd_vld ? ram_rdata : '0;
  assign slot_free = !out_valid || out_ready;
  assign ram_raddr = job.cidx;

  // lowest pending result
  always_comb begin
    fsel  = 4'(F_ERR);
    found = 1'b0;
    for (int i = 0; i < NFLAGS; i++) begin
      if (!found && flags[i]) begin
        fsel  = 4'(i);
        found = 1'b1;
      end
    end
    remaining = flags & ~(NFLAGS'(1) << fsel);
    last      = (remaining == '0);
    for (int c = 0; c < 3; c++) begin
      mag[c] = neg[c] ? 24'(-prod[c]) : 24'(prod[c]);
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    job_next   = job;
    flags_next = flags;
    emit       = 1'b0;
    load       = 1'b0;
    ram_re     = 1'b0;
    do_mul     = 1'b0;
    do_div     = 1'b0;
    res        = '0;
    res.kind   = K_COLOR;
    case (state)
      BK_IDLE: load = 1'b1;
      BK_RUN: begin
        if (fsel == 4'(F_COL1) || fsel == 4'(F_COL2)) begin
          ram_re     = 1'b1;
          state_next = BK_RDWAIT;
        end else if (slot_free) begin
          emit = 1'b1;
          case (fsel)
            4'(F_WIDTH): begin
              res.kind       = K_WIDTH;
              res.line_width = job.lwidth;
            end
            4'(F_BEGIN): res.kind = K_BEGIN;
            4'(F_POS1): begin
              res.kind  = job.pos1_kind;
              res.pos_x = job.x1;
              res.pos_y = job.y1;
              if (job.pos1_kind == K_MARKER) begin
                res.marker_kind = job.mkind;
                res.marker_half = job.mhalf;
              end
            end
            4'(F_POS2): begin
              res.kind  = K_DRAW;
              res.pos_x = job.x2;
              res.pos_y = job.y2;
            end
            4'(F_END):  res.kind = K_END;
            4'(F_CHR): begin
              res.kind      = K_CHAR;
              res.text_char = job.chr;
            end
            4'(F_TEND): res.kind = K_TEND;
            default:    res.kind = K_ERROR;
          endcase
        end
      end
      BK_RDWAIT: begin
        if (job.shade && fsel == 4'(F_COL1)) begin
          do_mul     = 1'b1;
          state_next = BK_MUL;
        end else if (slot_free) begin
          emit      = 1'b1;
          res.red   = {7'd0, col[23:16]};
          res.green = {7'd0, col[15:8]};
          res.blue  = {7'd0, col[7:0]};
        end
      end
      BK_MUL: begin
        do_div     = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        if (slot_free) begin
          emit      = 1'b1;
          res.red   = neg[0] ? 15'(-quot[0][47:DIV_SHIFT]) : quot[0][47:DIV_SHIFT];
          res.green = neg[1] ? 15'(-quot[1][47:DIV_SHIFT]) : quot[1][47:DIV_SHIFT];
          res.blue  = neg[2] ? 15'(-quot[2][47:DIV_SHIFT]) : quot[2][47:DIV_SHIFT];
        end
      end
      default: state_next = BK_IDLE;
    endcase
    res.last = last;
    if (emit) begin
      flags_next = remaining;
      if (last) begin
        load = 1'b1;
      end else begin
        state_next = BK_RUN;
      end
    end
    // take the next request
    q_pop  = load && q_valid;
    ram_we = q_pop && q_job.palwr;
    if (load) begin
      if (q_valid && !q_job.palwr) begin
        job_next   = q_job;
        flags_next = q_job.flags;
        state_next = BK_RUN;
      end else begin
        flags_next = '0;
        state_next = BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      flags     <= '0;
      pal_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      flags <= flags_next;
      if (ram_we) begin
        pal_valid[q_job.cidx] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and shading datapath
  always_ff @(posedge clk) begin
    job <= job_next;
    if (ram_re) begin
      rd_vld <= pal_valid[ram_raddr];
    end
    if (emit) begin
      out <= res;
    end
    if (do_mul) begin
      prod[0] <= $signed({1'b0, col[23:16]}) * $signed(job.inten);
      prod[1] <= $signed({1'b0, col[15:8]}) * $signed(job.inten);
      prod[2] <= $signed({1'b0, col[7:0]}) * $signed(job.inten);
      neg[0]  <= job.inten[15] && (col[23:16] != 8'd0);
      neg[1]  <= job.inten[15] && (col[15:8] != 8'd0);
      neg[2]  <= job.inten[15] && (col[7:0] != 8'd0);
    end
    if (do_div) begin
      for (int c = 0; c < 3; c++) begin
        quot[c] <= 48'(mag[c]) * 48'(DIV_RECIP);
      end
    end
  end

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> (flags != '0))
    else $error("executer busy with nothing pending");
  a_mul_is_shade: assert property (@(posedge clk) disable iff (rst)
    (state == BK_MUL) |-> job.shade)
    else $error("scaling path entered without shaded request");
  a_div_follows_mul: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV && $past(state) != BK_DIV) |-> ($past(state) == BK_MUL))
    else $error("scaled color without multiply");
endmodule
`default_nettype wire

FILE: rtl/metafile_command_decoder_unit.sv
// Top level of the metafile command decoder.
// The decoder takes one command byte per cycle on cmd and emits draw primitives on
// prim. The parser accepts a byte every cycle while its four-entry request queue has
// room; each byte yields at most one request. The executer sends at most one primitive
// per cycle while prim is ready; a palette color first waits for the palette RAM read,
// and a shaded color goes through read, scale by intensity, multiply by the reciprocal
// of 1000 and emit. The palette reads as zero after reset through a valid bit per
// entry, so no clearing pass is needed. The user must write byte_order on cfg only
// while idle, which the block does not enforce; byte_order resets to big endian.
`timescale 1ns / 1ps
`default_nettype none
module metafile_command_decoder_unit import mcd_pkg::*; #(
  parameter int MAX_POINTS = 50,
  parameter int MAX_TEXT   = 256
) (
  input logic         clk,
  input logic         rst,
  mcd_cfg_if.sink     cfg,
  mcd_cmd_if.sink     cmd,
  mcd_prim_if.source  prim
);
  logic byte_order;
  logic acc, q_full, q_empty, q_pop, job_valid;
  job_t job, q_job;
  res_t res;

  assign cfg.ready = 1'b1;
  assign cmd.ready = !q_full;
  assign acc       = cmd.valid && !q_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= 1'b1;
    end else if (cfg.valid) begin
      byte_order <= cfg.byte_order;
    end
  end

  mcd_front #(.MAX_POINTS(MAX_POINTS), .MAX_TEXT(MAX_TEXT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .data_byte  (cmd.data_byte),
    .restart    (cmd.restart),
    .byte_order (byte_order),
    .job        (job),
    .job_valid  (job_valid)
  );

  mcd_queue #(.DEPTH(4)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_valid),
    .din   (job),
    .pop   (q_pop),
    .dout  (q_job),
    .full  (q_full),
    .empty (q_empty)
  );

  mcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out       (res),
    .out_valid (prim.valid),
    .out_ready (prim.ready)
  );

  assign prim.kind        = res.kind;
  assign prim.pos_x       = res.pos_x;
  assign prim.pos_y       = res.pos_y;
  assign prim.red         = res.red;
  assign prim.green       = res.green;
  assign prim.blue        = res.blue;
  assign prim.line_width  = res.line_width;
  assign prim.marker_kind = res.marker_kind;
  assign prim.marker_half = res.marker_half;
  assign prim.text_char   = res.text_char;
  assign prim.last        = res.last;
endmodule
`default_nettype wire
